[rtl/mhpq_pkg.sv]
package mhpq_pkg;

   // Heap storage geometry.
   localparam int DEPTH     = 32;
   localparam int KEY_BITS  = 16;
   localparam int TAG_BITS  = 16;
   localparam int ADDR_BITS = $clog2(DEPTH);
   // Width of an entry count, which must be able to hold DEPTH itself.
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   // Width of a child index, which can run one level past the last entry.
   localparam int CIDX_BITS = ADDR_BITS + 1;

   // Capacity register.
   localparam int CAP_BITS = 6;
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(32);

   // Stream payload widths, rounded up to whole bytes.
   localparam int REQ_DATA_BITS = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((KEY_BITS + TAG_BITS + CNT_BITS + 7) / 8) * 8;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef struct packed {
      req_kind_type kind;
      entry_type    entry;
   } request_type;

   typedef struct packed {
      status_type          status;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
      logic [CNT_BITS-1:0] count;
   } result_type;

   // Command bundle from the sequencer to the entry store.
   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      entry_type            wr_data;
      logic [ADDR_BITS-1:0] rd_addr_a;
      logic [ADDR_BITS-1:0] rd_addr_b;
   } store_cmd_type;

endpackage

[rtl/max_heap_priority_queue_top.sv]
// Channel  | Ports                       | Contents (lowest bit first)
// ---------+-----------------------------+-----------------------------------------------
// request  | req_tvalid/tready/tdata/tuser | tdata: entry_key, entry_tag; tuser: req_type
// response | rsp_tvalid/tready/tdata/tuser | tdata: out_key, out_tag, entry_count; tuser: status
// config   | csr_wr_en/csr_wr_data       | capacity, written whenever csr_wr_en is high
//
// One item is handled at a time. A rejected item goes straight to the response
// register; an insert climbs from the new last slot one level at a time, and a removal
// reads the root and the last entry, then sinks that entry from the root one level at a
// time. The sequencer returns to idle, ready for the next item, at the same edge that
// loads the response register. The sift walk moves one heap level per cycle through
// the two-read-port entry store.
// Reset is synchronous and active high; it empties the heap and sets capacity to 32.
// The entry memory is not cleared: only entries below the count are ever used.
// A response waiting in the output register does not stop the next item from being
// accepted; that item's result waits in the sequencer until the register frees up.

module max_heap_priority_queue_top
   import mhpq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [15:0] entry_key, [31:16] entry_tag
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // [0] req_type
   input  logic                     req_tuser,

   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [15:0] out_key, [31:16] out_tag, [37:32] entry_count, upper bits zero
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]               rsp_tuser,

   input  logic                     csr_wr_en,
   input  logic [CAP_BITS-1:0]      csr_wr_data
);

   logic [CAP_BITS-1:0]      cap_ff;
   logic [CNT_BITS-1:0]      cap_limit;
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [1:0]               rsp_user_ff;

   logic          ctrl_idle;
   logic          ctrl_done;
   logic          slot_free;
   logic          start;
   request_type   request;
   result_type    result;
   store_cmd_type store_cmd;
   entry_type     rd_data_a;
   entry_type     rd_data_b;

   // Capacity register. Values above the store depth act as the depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   assign cap_limit = (int'(cap_ff) > DEPTH) ? CNT_BITS'(DEPTH) : CNT_BITS'(cap_ff);

   // The sequencer takes a new item whenever it has finished the previous one.
   assign req_tready = ctrl_idle;
   assign start      = req_tvalid && req_tready;

   assign request.kind      = req_kind_type'(req_tuser);
   assign request.entry.key = req_tdata[KEY_BITS-1:0];
   assign request.entry.tag = req_tdata[KEY_BITS +: TAG_BITS];

   // The output register is free when empty or being emptied this cycle.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .request   (request),
      .cap_limit (cap_limit),
      .slot_free (slot_free),
      .idle      (ctrl_idle),
      .done      (ctrl_done),
      .result    (result),
      .store_cmd (store_cmd),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mhpq_store u_store (
      .clock     (clock),
      .cmd       (store_cmd),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Response register between the sequencer and the downstream side.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctrl_done) begin
         rsp_data_ff <= RSP_DATA_BITS'({result.count, result.tag, result.key});
         rsp_user_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/mhpq_store.sv]
module mhpq_store
   import mhpq_pkg::*;
(
   input  logic          clock,
   input  store_cmd_type cmd,
   output entry_type     rd_data_a,
   output entry_type     rd_data_b
);

   // One write port and two read ports; read data is registered and appears in the
   // cycle after the address.
   entry_type mem [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_a_ff <= mem[cmd.rd_addr_a];
      rd_b_ff <= mem[cmd.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[rtl/mhpq_ctrl.sv]
module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  request_type         request,
   input  logic [CNT_BITS-1:0] cap_limit,
   input  logic                slot_free,
   output logic                idle,
   output logic                done,
   output result_type          result,
   output store_cmd_type       store_cmd,
   input  entry_type           rd_data_a,
   input  entry_type           rd_data_b
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOAD   = 6'b000010,
      S_UP     = 6'b000100,
      S_DOWN   = 6'b001000,
      S_FINAL  = 6'b010000,
      S_RESULT = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] pos_ff, pos_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   entry_type            carry_ff, carry_in;
   status_type           status_ff, status_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;

   logic [ADDR_BITS-1:0] last_addr;
   logic [ADDR_BITS-1:0] parent_idx;
   logic [ADDR_BITS-1:0] grand_idx;
   logic [CIDX_BITS-1:0] cnt_x;
   logic [CIDX_BITS-1:0] left_x;
   logic [CIDX_BITS-1:0] right_x;
   logic                 take_left;
   logic                 take_right;
   logic [ADDR_BITS-1:0] best_idx;
   entry_type            best_entry;
   logic [CIDX_BITS-1:0] next_left_x;
   logic [CIDX_BITS-1:0] next_right_x;
   logic                 full;

   assign full       = (cnt_ff >= cap_limit);
   assign last_addr  = ADDR_BITS'(cnt_ff) - ADDR_BITS'(1);
   assign parent_idx = (pos_ff - ADDR_BITS'(1)) >> 1;
   assign grand_idx  = (parent_idx - ADDR_BITS'(1)) >> 1;
   assign cnt_x      = CIDX_BITS'(cnt_ff);
   assign left_x     = {pos_ff, 1'b1};
   assign right_x    = left_x + CIDX_BITS'(1);

   // Pick the larger child; only a strictly greater key moves, left wins ties.
   always_comb begin
      take_left  = (left_x < cnt_x) && (rd_data_a.key > carry_ff.key);
      take_right = 1'b0;
      if (right_x < cnt_x) begin
         if (take_left) begin
            take_right = (rd_data_b.key > rd_data_a.key);
         end else begin
            take_right = (rd_data_b.key > carry_ff.key);
         end
      end
      if (take_right) begin
         best_idx   = right_x[ADDR_BITS-1:0];
         best_entry = rd_data_b;
      end else begin
         best_idx   = left_x[ADDR_BITS-1:0];
         best_entry = rd_data_a;
      end
      next_left_x  = {best_idx, 1'b1};
      next_right_x = next_left_x + CIDX_BITS'(1);
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      carry_in  = carry_ff;
      status_in = status_ff;
      key_in    = key_ff;
      tag_in    = tag_ff;
      done      = 1'b0;

      store_cmd.wr_en     = 1'b0;
      store_cmd.wr_addr   = pos_ff;
      store_cmd.wr_data   = carry_ff;
      store_cmd.rd_addr_a = '0;
      store_cmd.rd_addr_b = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = ST_DONE;
               key_in    = '0;
               tag_in    = '0;
               if (request.kind == REQ_INSERT) begin
                  if (full) begin
                     status_in = ST_FULL;
                     state_in  = S_RESULT;
                  end else begin
                     carry_in = request.entry;
                     cnt_in   = cnt_ff + CNT_BITS'(1);
                     pos_in   = ADDR_BITS'(cnt_ff);
                     if (cnt_ff == '0) begin
                        store_cmd.wr_en   = 1'b1;
                        store_cmd.wr_addr = '0;
                        store_cmd.wr_data = request.entry;
                        state_in          = S_RESULT;
                     end else begin
                        store_cmd.rd_addr_a = (ADDR_BITS'(cnt_ff) - ADDR_BITS'(1)) >> 1;
                        state_in            = S_UP;
                     end
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESULT;
                  end else begin
                     cnt_in              = cnt_ff - CNT_BITS'(1);
                     store_cmd.rd_addr_a = '0;
                     store_cmd.rd_addr_b = last_addr;
                     state_in            = S_LOAD;
                  end
               end
            end
         end
         S_LOAD: begin
            // Root leaves as the result; the last entry becomes the hole's
            // occupant and sinks from the root.
            key_in   = rd_data_a.key;
            tag_in   = rd_data_a.tag;
            carry_in = rd_data_b;
            pos_in   = '0;
            if (cnt_ff == '0) begin
               state_in = S_RESULT;
            end else if (cnt_ff == CNT_BITS'(1)) begin
               store_cmd.wr_en   = 1'b1;
               store_cmd.wr_addr = '0;
               store_cmd.wr_data = rd_data_b;
               state_in          = S_RESULT;
            end else begin
               store_cmd.rd_addr_a = ADDR_BITS'(1);
               store_cmd.rd_addr_b = ADDR_BITS'(2);
               state_in            = S_DOWN;
            end
         end
         S_UP: begin
            if (carry_ff.key > rd_data_a.key) begin
               store_cmd.wr_en   = 1'b1;
               store_cmd.wr_data = rd_data_a;
               pos_in            = parent_idx;
               if (parent_idx == '0) begin
                  state_in = S_FINAL;
               end else begin
                  store_cmd.rd_addr_a = grand_idx;
               end
            end else begin
               store_cmd.wr_en = 1'b1;
               state_in        = S_RESULT;
            end
         end
         S_DOWN: begin
            if (take_left || take_right) begin
               store_cmd.wr_en   = 1'b1;
               store_cmd.wr_data = best_entry;
               pos_in            = best_idx;
               if (next_left_x >= cnt_x) begin
                  state_in = S_FINAL;
               end else begin
                  store_cmd.rd_addr_a = next_left_x[ADDR_BITS-1:0];
                  store_cmd.rd_addr_b = next_right_x[ADDR_BITS-1:0];
               end
            end else begin
               store_cmd.wr_en = 1'b1;
               state_in        = S_RESULT;
            end
         end
         S_FINAL: begin
            store_cmd.wr_en = 1'b1;
            state_in        = S_RESULT;
         end
         S_RESULT: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      pos_ff    <= pos_in;
      carry_ff  <= carry_in;
      status_ff <= status_in;
      key_ff    <= key_in;
      tag_ff    <= tag_in;
   end

   assign idle          = (state_ff == S_IDLE);
   assign result.status = status_ff;
   assign result.key    = key_ff;
   assign result.tag    = tag_ff;
   assign result.count  = cnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(DEPTH))
      else $error("entry count exceeds the store depth");

   a_up_not_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP) |-> (pos_ff != '0))
      else $error("sift up reached the root without finishing");

   a_down_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DOWN) |-> (left_x < cnt_x))
      else $error("sift down visited a node without children");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (idle && start && request.kind == REQ_INSERT && !full)
      |=> (cnt_ff == $past(cnt_ff) + CNT_BITS'(1)))
      else $error("accepted insert did not raise the count");

   a_read_write_apart: assert property (@(posedge clock) disable iff (reset)
      (store_cmd.wr_en && (state_ff == S_UP) && (state_in == S_UP))
      |-> (store_cmd.rd_addr_a != store_cmd.wr_addr))
      else $error("sift up reads the entry it writes");

endmodule
